// ===== design/max_pool_2d_argmax_assert.svh =====
// Assertion macros for the max pooling block.
// Expects clk and rst_n in the including scope; define NO_ASSERTIONS to drop them.
`ifndef MAX_POOL_2D_ARGMAX_ASSERT_SVH
`define MAX_POOL_2D_ARGMAX_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define MP2A_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("max_pool_2d_argmax: same-cycle check failed");
`define MP2A_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("max_pool_2d_argmax: next-cycle check failed");
`else
`define MP2A_ASSERT_SAME(lbl, ante, cons)
`define MP2A_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/mp2a_pkg.sv =====
// Shared constants, register codes and the window job record for max pooling.
// No dependencies.
package mp2a_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int MAX_KERNEL  = 8;
  localparam int SAMPLE_BITS = 32;

  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int SLOT_W      = $clog2(MAX_KERNEL);
  localparam int ADDR_W      = SLOT_W + COL_W;
  localparam int STORE_DEPTH = MAX_KERNEL * MAX_WIDTH;

  localparam int DIM_W      = 9;
  localparam int KER_W      = 4;
  localparam int PLANE_W    = 16;
  localparam int IDX_W      = 32;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_HEIGHT   = 3'd0,
    REG_IN_WIDTH    = 3'd1,
    REG_KERNEL_ROWS = 3'd2,
    REG_KERNEL_COLS = 3'd3,
    REG_STRIDE_ROWS = 3'd4,
    REG_STRIDE_COLS = 3'd5,
    REG_NUM_PLANES  = 3'd6
  } reg_idx_t;

  localparam logic [DIM_W-1:0]   RST_IN_HEIGHT   = 9'd32;
  localparam logic [DIM_W-1:0]   RST_IN_WIDTH    = 9'd32;
  localparam logic [KER_W-1:0]   RST_KERNEL_ROWS = 4'd2;
  localparam logic [KER_W-1:0]   RST_KERNEL_COLS = 4'd2;
  localparam logic [KER_W-1:0]   RST_STRIDE_ROWS = 4'd2;
  localparam logic [KER_W-1:0]   RST_STRIDE_COLS = 4'd2;
  localparam logic [PLANE_W-1:0] RST_NUM_PLANES  = 16'd1;

  typedef struct packed {
    logic [IDX_W-1:0]  start_idx;
    logic [COL_W-1:0]  c0;
    logic [SLOT_W-1:0] slot0;
    logic [KER_W-1:0]  kr;
    logic [KER_W-1:0]  kc;
    logic [DIM_W-1:0]  width;
    logic              last_plane;
    logic              last_tensor;
  } job_t;

endpackage

// ===== design/mp2a_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mp2a_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/mp2a_pos.sv =====
// Configuration registers, raster position counters and window completion test.
// Depends on mp2a_pkg.
module mp2a_pos (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [mp2a_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mp2a_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   in_valid,
  input  logic                                   in_stall,
  input  logic signed [mp2a_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                   ram_we,
  output logic [mp2a_pkg::ADDR_W-1:0]            ram_waddr,
  output logic [mp2a_pkg::SAMPLE_BITS-1:0]       ram_wdata,
  output logic                                   job_valid,
  output mp2a_pkg::job_t                         job
);

  localparam int DW = mp2a_pkg::DIM_W;
  localparam int KW = mp2a_pkg::KER_W;
  localparam int SW = mp2a_pkg::SLOT_W;
  localparam int CW = mp2a_pkg::COL_W;
  localparam int RW = mp2a_pkg::ROW_W;
  localparam int PW = mp2a_pkg::PLANE_W;
  localparam int XW = mp2a_pkg::IDX_W;

  logic [DW-1:0] in_height_r, in_width_r;
  logic [KW-1:0] kernel_rows_r, kernel_cols_r, stride_rows_r, stride_cols_r;
  logic [PW-1:0] num_planes_r;

  logic [RW-1:0] row_r, row_nxt, row_c;
  logic [CW-1:0] col_r, col_nxt, col_c;
  logic [SW-1:0] rph_r, rph_nxt, rph_c;
  logic [KW-1:0] cph_r, cph_nxt, cph_c;
  logic [KW-1:0] rsp_r, rsp_nxt, rsp_c;
  logic [PW-1:0] plane_r, plane_nxt, plane_c;
  logic [XW-1:0] flat_r, flat_nxt, flat_c;

  logic [DW-1:0] h_eff, w_eff;
  logic [PW-1:0] p_eff;
  logic          acc, bad, kvalid, col_last, row_last, col_ok, row_ok, ready;
  logic          cfg_hit, plane_wrap;
  logic [DW-1:0] col1, row1;
  logic [KW:0]   cph1, rsp1;
  logic [PW:0]   plane1;
  logic [KW-1:0] rph1;
  logic [SW-1:0] km1, kcm1;
  logic [DW+SW-1:0] win_off;
  logic [RW-1:0] r0;
  logic [CW-1:0] c0;
  logic [DW:0]   lp_rows, lp_cols;
  logic          last_plane;

  always_comb begin
    h_eff = (in_height_r == '0) ? DW'(1) :
            (in_height_r > DW'(mp2a_pkg::MAX_HEIGHT)) ? DW'(mp2a_pkg::MAX_HEIGHT) : in_height_r;
    w_eff = (in_width_r == '0) ? DW'(1) :
            (in_width_r > DW'(mp2a_pkg::MAX_WIDTH)) ? DW'(mp2a_pkg::MAX_WIDTH) : in_width_r;
    p_eff = (num_planes_r == '0) ? PW'(1) : num_planes_r;

    acc = in_valid && !in_stall;
    bad = (DW'(row_r) >= h_eff) || (DW'(col_r) >= w_eff);

    row_c   = bad ? '0 : row_r;
    col_c   = bad ? '0 : col_r;
    rph_c   = bad ? '0 : rph_r;
    cph_c   = bad ? '0 : cph_r;
    rsp_c   = bad ? '0 : rsp_r;
    plane_c = bad ? '0 : plane_r;
    flat_c  = bad ? '0 : flat_r;

    kvalid = (kernel_rows_r != '0) && (kernel_rows_r <= KW'(mp2a_pkg::MAX_KERNEL)) &&
             (kernel_cols_r != '0) && (kernel_cols_r <= KW'(mp2a_pkg::MAX_KERNEL)) &&
             (stride_rows_r != '0) && (stride_cols_r != '0);

    col1     = DW'(col_c) + DW'(1);
    row1     = DW'(row_c) + DW'(1);
    col_last = col1 >= w_eff;
    row_last = row1 >= h_eff;
    col_ok   = col1 >= DW'(kernel_cols_r);
    row_ok   = row1 >= DW'(kernel_rows_r);
    ready    = kvalid && col_ok && row_ok && (cph_c == '0) && (rsp_c == '0);

    cph1   = (KW+1)'(cph_c) + (KW+1)'(1);
    rsp1   = (KW+1)'(rsp_c) + (KW+1)'(1);
    rph1   = KW'(rph_c) + KW'(1);
    plane1 = (PW+1)'(plane_c) + (PW+1)'(1);
    plane_wrap = plane1 >= (PW+1)'(p_eff);

    col_nxt   = col_last ? '0 : col_c + CW'(1);
    cph_nxt   = cph_c;
    row_nxt   = row_c;
    rph_nxt   = rph_c;
    rsp_nxt   = rsp_c;
    plane_nxt = plane_c;
    flat_nxt  = (col_last && row_last && plane_wrap) ? '0 : flat_c + XW'(1);

    if (kvalid && col_ok) begin
      cph_nxt = (cph1 >= (KW+1)'(stride_cols_r)) ? '0 : cph1[KW-1:0];
    end
    if (col_last) begin
      cph_nxt = '0;
      if (row_last) begin
        row_nxt   = '0;
        rph_nxt   = '0;
        rsp_nxt   = '0;
        plane_nxt = plane_wrap ? '0 : plane1[PW-1:0];
      end else begin
        row_nxt = row_c + RW'(1);
        rph_nxt = (kvalid && (rph1 < kernel_rows_r)) ? rph1[SW-1:0] : '0;
        if (row_ok) begin
          rsp_nxt = (rsp1 >= (KW+1)'(stride_rows_r)) ? '0 : rsp1[KW-1:0];
        end else begin
          rsp_nxt = '0;
        end
      end
    end

    km1     = SW'(kernel_rows_r - KW'(1));
    kcm1    = SW'(kernel_cols_r - KW'(1));
    win_off = (DW+SW)'(km1) * (DW+SW)'(w_eff);
    r0      = row_c - RW'(km1);
    c0      = col_c - CW'(kcm1);
    lp_rows = (DW+1)'(r0) + (DW+1)'(stride_rows_r) + (DW+1)'(kernel_rows_r);
    lp_cols = (DW+1)'(c0) + (DW+1)'(stride_cols_r) + (DW+1)'(kernel_cols_r);
    last_plane = (lp_rows > (DW+1)'(h_eff)) && (lp_cols > (DW+1)'(w_eff));

    job.start_idx   = flat_c - XW'(win_off) - XW'(kcm1);
    job.c0          = c0;
    job.slot0       = (rph1 == kernel_rows_r) ? '0 : rph1[SW-1:0];
    job.kr          = kernel_rows_r;
    job.kc          = kernel_cols_r;
    job.width       = w_eff;
    job.last_plane  = last_plane;
    job.last_tensor = last_plane && plane_wrap;
    job_valid       = acc && ready;

    ram_we    = acc && kvalid;
    ram_waddr = {rph_c, col_c};
    ram_wdata = in_sample;

    cfg_hit = 1'b0;
    unique case (cfg_index) inside
      mp2a_pkg::REG_IN_HEIGHT, mp2a_pkg::REG_IN_WIDTH, mp2a_pkg::REG_KERNEL_ROWS,
      mp2a_pkg::REG_KERNEL_COLS, mp2a_pkg::REG_STRIDE_ROWS, mp2a_pkg::REG_STRIDE_COLS,
      mp2a_pkg::REG_NUM_PLANES: cfg_hit = cfg_wr_en;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_height_r   <= mp2a_pkg::RST_IN_HEIGHT;
      in_width_r    <= mp2a_pkg::RST_IN_WIDTH;
      kernel_rows_r <= mp2a_pkg::RST_KERNEL_ROWS;
      kernel_cols_r <= mp2a_pkg::RST_KERNEL_COLS;
      stride_rows_r <= mp2a_pkg::RST_STRIDE_ROWS;
      stride_cols_r <= mp2a_pkg::RST_STRIDE_COLS;
      num_planes_r  <= mp2a_pkg::RST_NUM_PLANES;
      row_r   <= '0;
      col_r   <= '0;
      rph_r   <= '0;
      cph_r   <= '0;
      rsp_r   <= '0;
      plane_r <= '0;
      flat_r  <= '0;
    end else if (cfg_hit) begin
      unique case (cfg_index)
        mp2a_pkg::REG_IN_HEIGHT:   in_height_r   <= cfg_data[DW-1:0];
        mp2a_pkg::REG_IN_WIDTH:    in_width_r    <= cfg_data[DW-1:0];
        mp2a_pkg::REG_KERNEL_ROWS: kernel_rows_r <= cfg_data[KW-1:0];
        mp2a_pkg::REG_KERNEL_COLS: kernel_cols_r <= cfg_data[KW-1:0];
        mp2a_pkg::REG_STRIDE_ROWS: stride_rows_r <= cfg_data[KW-1:0];
        mp2a_pkg::REG_STRIDE_COLS: stride_cols_r <= cfg_data[KW-1:0];
        mp2a_pkg::REG_NUM_PLANES:  num_planes_r  <= cfg_data[PW-1:0];
        default: ;
      endcase
      row_r   <= '0;
      col_r   <= '0;
      rph_r   <= '0;
      cph_r   <= '0;
      rsp_r   <= '0;
      plane_r <= '0;
      flat_r  <= '0;
    end else if (acc) begin
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      rph_r   <= rph_nxt;
      cph_r   <= cph_nxt;
      rsp_r   <= rsp_nxt;
      plane_r <= plane_nxt;
      flat_r  <= flat_nxt;
    end
  end

endmodule

// ===== design/mp2a_scan.sv =====
// Window scan sequencer: reads the row store over the window, tracks the argmax,
// and holds the result in the output register. Depends on mp2a_pkg.
module mp2a_scan (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 job_valid,
  input  mp2a_pkg::job_t                       job,
  input  logic [mp2a_pkg::SAMPLE_BITS-1:0]     ram_rdata,
  output logic                                 ram_re,
  output logic [mp2a_pkg::ADDR_W-1:0]          ram_raddr,
  output logic                                 busy,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mp2a_pkg::SAMPLE_BITS-1:0] out_max_value,
  output logic [mp2a_pkg::IDX_W-1:0]           out_max_index,
  output logic                                 out_last_of_plane,
  output logic                                 out_last_of_tensor
);

  localparam int KW = mp2a_pkg::KER_W;
  localparam int SW = mp2a_pkg::SLOT_W;
  localparam int CW = mp2a_pkg::COL_W;
  localparam int XW = mp2a_pkg::IDX_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WAIT, S_FLUSH} state_t;

  state_t         state_r;
  mp2a_pkg::job_t job_r;
  logic [SW-1:0]  dc_r, dr_r, slot_r;
  logic [CW-1:0]  col_r;
  logic [XW-1:0]  elem_r, rowi_r, rd_idx_r, peak_idx_r;
  logic           rd_vld_r, rd_first_r;
  logic signed [mp2a_pkg::SAMPLE_BITS-1:0] best_r;
  logic           col_end, row_end, take, out_free;
  logic [XW-1:0]  rowi_step;
  logic [KW-1:0]  slot1;

  always_comb begin
    ram_re    = (state_r == S_SCAN);
    ram_raddr = {slot_r, col_r};
    busy      = (state_r != S_IDLE);
    col_end   = KW'(dc_r) == (job_r.kc - KW'(1));
    row_end   = KW'(dr_r) == (job_r.kr - KW'(1));
    slot1     = KW'(slot_r) + KW'(1);
    rowi_step = rowi_r + XW'(job_r.width);
    take      = rd_first_r || ($signed(ram_rdata) > best_r);
    out_free  = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      rd_vld_r  <= 1'b0;
    end else begin
      if ((state_r == S_FLUSH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      rd_vld_r   <= ram_re;
      rd_first_r <= ram_re && (dc_r == '0) && (dr_r == '0);
      rd_idx_r   <= elem_r;
      if (rd_vld_r && take) begin
        best_r     <= $signed(ram_rdata);
        peak_idx_r <= rd_idx_r;
      end
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            job_r   <= job;
            dc_r    <= '0;
            dr_r    <= '0;
            slot_r  <= job.slot0;
            col_r   <= job.c0;
            elem_r  <= job.start_idx;
            rowi_r  <= job.start_idx;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (col_end) begin
            dc_r   <= '0;
            dr_r   <= dr_r + SW'(1);
            col_r  <= job_r.c0;
            slot_r <= (slot1 == job_r.kr) ? '0 : slot1[SW-1:0];
            rowi_r <= rowi_step;
            elem_r <= rowi_step;
            if (row_end) begin
              state_r <= S_WAIT;
            end
          end else begin
            dc_r   <= dc_r + SW'(1);
            col_r  <= col_r + CW'(1);
            elem_r <= elem_r + XW'(1);
          end
        end
        S_WAIT: state_r <= S_FLUSH;
        S_FLUSH: begin
          if (out_free) begin
            out_max_value      <= best_r;
            out_max_index      <= peak_idx_r;
            out_last_of_plane  <= job_r.last_plane;
            out_last_of_tensor <= job_r.last_tensor;
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/max_pool_2d_argmax.sv =====
// Top level of the 2-D max pooling block with argmax.
// Depends on mp2a_pkg, mp2a_ram, mp2a_pos, mp2a_scan and the assertion header.

// Samples stream in raster order, plane after plane; the last kernel_rows rows sit
// in a 2048 x 32 row store (kernel slot by column) that is never cleared, since a
// window only reads entries written earlier in its own plane. A sample that
// completes no window is taken without a stall, so such samples go back to back. A
// sample that completes a window is written, then the window is read back through
// the store's single read port one entry per cycle, and the input stalls while the
// scan walks the window, through a wait state, and in the flush state until the
// result moves into the output register (longer if the output register is still
// waiting to be taken). Configuration writes restart the position counters and
// keep the store contents.
`include "max_pool_2d_argmax_assert.svh"

module max_pool_2d_argmax (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [mp2a_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mp2a_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [mp2a_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [mp2a_pkg::SAMPLE_BITS-1:0] out_max_value,
  output logic [mp2a_pkg::IDX_W-1:0]             out_max_index,
  output logic                                   out_last_of_plane,
  output logic                                   out_last_of_tensor
);

  logic                                 ram_we, ram_re, job_valid, busy;
  logic [mp2a_pkg::ADDR_W-1:0]          ram_waddr, ram_raddr;
  logic [mp2a_pkg::SAMPLE_BITS-1:0]     ram_wdata, ram_rdata;
  mp2a_pkg::job_t                       job;

  assign in_stall = busy;

  mp2a_pos u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (busy),
    .in_sample (in_sample),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .job_valid (job_valid),
    .job       (job)
  );

  mp2a_ram #(
    .WIDTH (mp2a_pkg::SAMPLE_BITS),
    .DEPTH (mp2a_pkg::STORE_DEPTH)
  ) u_row_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mp2a_scan u_scan (
    .clk                (clk),
    .rst_n              (rst_n),
    .job_valid          (job_valid),
    .job                (job),
    .ram_rdata          (ram_rdata),
    .ram_re             (ram_re),
    .ram_raddr          (ram_raddr),
    .busy               (busy),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_max_value      (out_max_value),
    .out_max_index      (out_max_index),
    .out_last_of_plane  (out_last_of_plane),
    .out_last_of_tensor (out_last_of_tensor)
  );

  `MP2A_ASSERT_SAME(a_no_write_during_scan, ram_re, !ram_we)
  `MP2A_ASSERT_SAME(a_stall_while_reading, ram_re, in_stall)
  `MP2A_ASSERT_NEXT(a_job_starts_scan, job_valid, ram_re && in_stall)

endmodule
